// ----- rtl/vgmcsp_pkg.sv -----
// Shared types and command codes for the command stream parser.
// No dependencies; imported by the decode, filter and top-level modules.
`default_nettype none

package vgmcsp_pkg;

  localparam logic [7:0] CODE_PSG_WRITE  = 8'h50;
  localparam logic [7:0] CODE_WAIT_WORD  = 8'h61;
  localparam logic [7:0] CODE_WAIT_60HZ  = 8'h62;
  localparam logic [7:0] CODE_WAIT_50HZ  = 8'h63;
  localparam logic [7:0] CODE_END        = 8'h66;
  localparam logic [7:0] CODE_DATA_BLOCK = 8'h67;
  localparam logic [7:0] CODE_PCM_WRITE  = 8'h68;

  localparam logic [15:0] WAIT_60HZ_SAMPLES = 16'd735;
  localparam logic [15:0] WAIT_50HZ_SAMPLES = 16'd882;

  // data block header: code, 0x66 marker, type, then 4 size bytes
  localparam logic [31:0] DATA_BLOCK_HDR_LEN = 32'd7;
  localparam logic [31:0] DATA_BLOCK_SIZE_IDX = 32'd6;
  localparam logic [30:0] DATA_BLOCK_SIZE_MASK = 31'h7FFF_FFFF;

  localparam logic [31:0] START_OFFSET_RESET = 32'd64;

  typedef struct packed {
    logic [3:0] len;
    logic       known;
  } cmd_info_t;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic [7:0] third;
  } filter_in_t;

endpackage

`default_nettype wire

// ----- rtl/vgmcsp_core.sv -----
// Top level of the command stream parser: input register, parse logic, result register.
// Depends on vgmcsp_pkg, vgmcsp_cmd_decode and vgmcsp_filter.
`default_nettype none

// A result word passes the input register, which takes its closing byte, then
// the result register. Throughput: one byte per cycle unless out_stall holds a
// result; the parse state updates in a single pass of table decode, the data
// block length add, one compare and the counter adds.
// A byte that completes no kept command gives no result; after end of data
// every byte is taken and discarded until reset.
// Reset (synchronous): all counters cleared, byte position back to 64.
module vgm_command_stream_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] start_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      cmd_position,
  output logic [31:0]      sample_count,
  output logic [3:0]       cmd_length,
  output logic [7:0]       cmd_code,
  output logic [31:0]      param_value,
  output logic             is_end,
  output logic             is_unknown
);
  import vgmcsp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // parse state
  logic [7:0]  current_code;
  logic [31:0] byte_index;
  logic [31:0] command_length;
  logic [23:0] first_params;
  logic [31:0] packed_value;
  logic [31:0] sample_total;
  logic [31:0] byte_position;
  logic        stopped;
  logic        code_known;

  logic [7:0]  code_eff;
  logic [31:0] len_eff;
  logic [23:0] fp_eff;
  logic [31:0] pv_eff;
  logic [15:0] addend;
  logic [31:0] idx_inc;
  logic        known_eff;
  logic        code_phase;
  logic        done;
  logic        drop;
  logic        emit;
  logic        s1_go;
  logic [31:0] size_le;

  cmd_info_t  dec_info;
  filter_in_t fin;

  vgmcsp_cmd_decode u_decode (
    .code (s1_byte),
    .info (dec_info)
  );

  assign fin = '{code: code_eff, reg_addr: fp_eff[23:16], reg_data: fp_eff[15:8],
                 third: fp_eff[7:0]};

  vgmcsp_filter u_filter (
    .fin  (fin),
    .drop (drop)
  );

  assign code_phase = (byte_index == 32'd0);
  assign idx_inc    = byte_index + 32'd1;

  always_comb begin
    pv_eff  = {packed_value[23:0], s1_byte};
    size_le = {pv_eff[7:0], pv_eff[15:8], pv_eff[23:16], pv_eff[31:24]};
    addend  = 16'd0;
    if (code_phase) begin
      code_eff  = s1_byte;
      len_eff   = {28'd0, dec_info.len};
      known_eff = dec_info.known;
      fp_eff    = 24'd0;
      pv_eff    = 32'd0;
      if (s1_byte == CODE_WAIT_60HZ) begin
        addend = WAIT_60HZ_SAMPLES;
      end else if (s1_byte == CODE_WAIT_50HZ) begin
        addend = WAIT_50HZ_SAMPLES;
      end else if (s1_byte[7:4] == 4'h7) begin
        addend = {12'd0, s1_byte[3:0]} + 16'd1;
      end else if (s1_byte[7:4] == 4'h8) begin
        addend = {12'd0, s1_byte[3:0]};
      end
    end else begin
      code_eff  = current_code;
      known_eff = code_known;
      fp_eff    = first_params;
      case (byte_index[1:0])
        2'd1:    if (byte_index[31:2] == 30'd0) fp_eff[23:16] = s1_byte;
        2'd2:    if (byte_index[31:2] == 30'd0) fp_eff[15:8] = s1_byte;
        2'd3:    if (byte_index[31:2] == 30'd0) fp_eff[7:0] = s1_byte;
        default: fp_eff = first_params;
      endcase
      if (current_code == CODE_DATA_BLOCK && byte_index == DATA_BLOCK_SIZE_IDX) begin
        len_eff = DATA_BLOCK_HDR_LEN + {1'b0, size_le[30:0] & DATA_BLOCK_SIZE_MASK};
      end else begin
        len_eff = command_length;
      end
      // word wait is little endian in parameter bytes 1 and 2
      if (current_code == CODE_WAIT_WORD && idx_inc >= len_eff) begin
        addend = {pv_eff[7:0], pv_eff[15:8]};
      end
    end
  end

  assign done  = (idx_inc >= len_eff);
  assign emit  = s1_valid && !stopped && done && (code_eff == CODE_END || !drop);
  assign s1_go = s1_valid && (!emit || !out_valid || !out_stall);

  assign in_stall  = s1_valid && !s1_go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_code   <= 8'd0;
      byte_index     <= 32'd0;
      command_length <= 32'd0;
      first_params   <= 24'd0;
      packed_value   <= 32'd0;
      sample_total   <= 32'd0;
      byte_position  <= START_OFFSET_RESET;
      stopped        <= 1'b0;
      code_known     <= 1'b1;
    end else begin
      if (s1_go && !stopped) begin
        current_code   <= code_eff;
        code_known     <= known_eff;
        command_length <= len_eff;
        first_params   <= fp_eff;
        packed_value   <= pv_eff;
        sample_total   <= sample_total + {16'd0, addend};
        if (done) begin
          byte_index    <= 32'd0;
          byte_position <= byte_position + len_eff;
          if (code_eff == CODE_END) begin
            stopped <= 1'b1;
          end
        end else begin
          byte_index <= idx_inc;
        end
      end
      if (cfg_valid && cfg_ready) begin
        byte_position <= start_offset;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_go && emit) begin
      cmd_position <= byte_position;
      sample_count <= sample_total + {16'd0, addend};
      cmd_length   <= len_eff[3:0];
      cmd_code     <= code_eff;
      param_value  <= pv_eff;
      is_end       <= (code_eff == CODE_END);
      is_unknown   <= !known_eff;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vgmcsp_cmd_decode.sv -----
// Command length table: code byte -> length in bytes and known flag.
// Depends on vgmcsp_pkg.
`default_nettype none

module vgmcsp_cmd_decode (
  input  wire logic [7:0]             code,
  output vgmcsp_pkg::cmd_info_t       info
);
  import vgmcsp_pkg::*;

  always_comb begin
    info.known = 1'b1;
    info.len   = 4'd1;
    if (code >= 8'h70 && code <= 8'h8F) begin
      info.len = 4'd1;
    end else begin
      case (code)
        CODE_END, CODE_WAIT_60HZ, CODE_WAIT_50HZ: info.len = 4'd1;
        CODE_WAIT_WORD:                           info.len = 4'd3;
        CODE_PSG_WRITE:                           info.len = 4'd2;
        CODE_DATA_BLOCK:                          info.len = 4'd7;
        CODE_PCM_WRITE:                           info.len = 4'd12;
        8'h90, 8'h91, 8'h95:                      info.len = 4'd5;
        8'h92:                                    info.len = 4'd6;
        8'h93:                                    info.len = 4'd11;
        8'h94:                                    info.len = 4'd2;
        8'h41:                                    info.len = 4'd3;
        default: begin
          case (code[7:4])
            4'h3, 4'h4:       info.len = 4'd2;
            4'h5, 4'hA, 4'hB: info.len = 4'd3;
            4'hC, 4'hD:       info.len = 4'd4;
            4'hE, 4'hF:       info.len = 4'd5;
            default: begin
              info.len   = 4'd1;
              info.known = 1'b0;
            end
          endcase
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vgmcsp_filter.sv -----
// Register filter: flags completed commands whose words are dropped.
// Depends on vgmcsp_pkg.
`default_nettype none

module vgmcsp_filter (
  input  wire vgmcsp_pkg::filter_in_t fin,
  output logic                        drop
);
  import vgmcsp_pkg::*;

  logic [7:0] c;
  logic [7:0] r;
  logic [7:0] v;
  logic [7:0] p3;
  logic       opn_code;
  logic       opn_reg;

  assign c  = fin.code;
  assign r  = fin.reg_addr;
  assign v  = fin.reg_data;
  assign p3 = fin.third;

  assign opn_code = (c == 8'h52) || (c == 8'h53) || (c == 8'h55) ||
                    (c == 8'h56) || (c == 8'h58);
  assign opn_reg  = (r == 8'h2A) || (r >= 8'h24 && r <= 8'h27) ||
                    ((r & 8'hBC) == 8'hB4) || (r == 8'h0E) || (r == 8'h0F);

  always_comb begin
    drop = 1'b0;
    if (c >= 8'h60 && c <= 8'h8F) drop = 1'b1;
    if (opn_code && opn_reg) drop = 1'b1;
    if (c == 8'h58 && (r == 8'h1C || (r >= 8'h19 && r <= 8'h1B) ||
                       r <= 8'h05 || (r >= 8'h08 && r <= 8'h0A)))
      drop = 1'b1;
    if (c == 8'h54 && r >= 8'h10 && r <= 8'h14) drop = 1'b1;
    if (((c >= 8'h5A && c <= 8'h5C) || c == 8'h5E) && r >= 8'h02 && r <= 8'h04)
      drop = 1'b1;
    if (c == 8'h5D && (r & 8'hE3) == 8'h03) drop = 1'b1;
    if (c == 8'hC1 || c == 8'hC2) drop = 1'b1;
    if (c == 8'hA0 && (r == 8'h0E || r == 8'h0F)) drop = 1'b1;
    if ((c == 8'hB0 || c == 8'hB1) && r == 8'h07) drop = 1'b1;
    if (c == 8'hB2 && (r & 8'hF0) >= 8'h20 && (r & 8'hF0) <= 8'h40) drop = 1'b1;
    if (c == 8'hD1 && r == 8'h06) drop = 1'b1;
    if (c == 8'hD4 && (r & 8'h7F) == 8'h01 && (v & 8'hF0) == 8'hF0) drop = 1'b1;
    if (c == 8'hB7 && r == 8'h01) drop = 1'b1;
    if (c == 8'hB5 && r >= 8'h01) drop = 1'b1;
    if (c == 8'hC4 && p3 >= 8'h80) drop = 1'b1;
  end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for vgm_command_stream_parser_core: drives a byte stream
// through the input channel and compares every result word against a local parser.
// Depends on vgmcsp_pkg and the core top level; nothing else.
`timescale 1ns / 100ps

module tb;
  import vgmcsp_pkg::*;

  // command codes used by the length table and the register filter
  localparam logic [7:0] OP_NONE       = 8'h00;
  localparam logic [7:0] OP_PAIR_WR    = 8'h41;
  localparam logic [7:0] OP_FM_A0      = 8'h52;
  localparam logic [7:0] OP_FM_A1      = 8'h53;
  localparam logic [7:0] OP_FM_B       = 8'h54;
  localparam logic [7:0] OP_FM_C       = 8'h55;
  localparam logic [7:0] OP_FM_D0      = 8'h56;
  localparam logic [7:0] OP_FM_E0      = 8'h58;
  localparam logic [7:0] OP_OPL_LO     = 8'h5A;
  localparam logic [7:0] OP_OPL_HI     = 8'h5C;
  localparam logic [7:0] OP_PCM_Z      = 8'h5D;
  localparam logic [7:0] OP_OPL_X      = 8'h5E;
  localparam logic [7:0] OP_GROUP_LO   = 8'h60;
  localparam logic [7:0] OP_WAIT_N_LO  = 8'h70;
  localparam logic [7:0] OP_WAIT_N_HI  = 8'h7F;
  localparam logic [7:0] OP_WAIT_M_LO  = 8'h80;
  localparam logic [7:0] OP_WAIT_M_HI  = 8'h8F;
  localparam logic [7:0] OP_STRM_SETUP = 8'h90;
  localparam logic [7:0] OP_STRM_DATA  = 8'h91;
  localparam logic [7:0] OP_STRM_FREQ  = 8'h92;
  localparam logic [7:0] OP_STRM_START = 8'h93;
  localparam logic [7:0] OP_STRM_STOP  = 8'h94;
  localparam logic [7:0] OP_STRM_FAST  = 8'h95;
  localparam logic [7:0] OP_REG_A0     = 8'hA0;
  localparam logic [7:0] OP_REG_B0     = 8'hB0;
  localparam logic [7:0] OP_REG_B1     = 8'hB1;
  localparam logic [7:0] OP_REG_B2     = 8'hB2;
  localparam logic [7:0] OP_REG_B5     = 8'hB5;
  localparam logic [7:0] OP_REG_B7     = 8'hB7;
  localparam logic [7:0] OP_RAM_W0     = 8'hC1;
  localparam logic [7:0] OP_RAM_W1     = 8'hC2;
  localparam logic [7:0] OP_MEM_C4     = 8'hC4;
  localparam logic [7:0] OP_REG_D1     = 8'hD1;
  localparam logic [7:0] OP_REG_D4     = 8'hD4;
  localparam logic [7:0] OP_TOP        = 8'hFF;

  localparam int DIR_N       = 24;
  localparam int PHASES      = 6;
  localparam int PHASE_BYTES = 280;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] samples;
    logic [3:0]  len;
    logic [7:0]  code;
    logic [31:0] params;
    logic        at_end;
    logic        unknown;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    cmd_word_t  w;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] start_offset;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] cmd_position;
  logic [31:0] sample_count;
  logic [3:0]  cmd_length;
  logic [7:0]  cmd_code;
  logic [31:0] param_value;
  logic        is_end;
  logic        is_unknown;

  vgm_command_stream_parser_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .start_offset (start_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd_position (cmd_position),
    .sample_count (sample_count),
    .cmd_length   (cmd_length),
    .cmd_code     (cmd_code),
    .param_value  (param_value),
    .is_end       (is_end),
    .is_unknown   (is_unknown)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local parser state
  logic [7:0]  cur_code;
  logic [31:0] cur_idx;
  logic [31:0] cur_len;
  logic [23:0] head_bytes;
  logic [31:0] tail_bytes;
  logic [31:0] sample_acc;
  logic [31:0] cmd_pos;
  logic        halted;

  cmd_word_t   pending_words[$];
  dir_row_t    dir_tab [0:DIR_N-1];

  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_seen = 0;
  int unsigned stall_cycles = 0;
  int          rx_wait = 0;
  bit          rx_burst = 1'b0;
  bit          tx_burst = 1'b0;
  bit          rx_hold = 1'b0;
  bit          hold_go = 1'b0;

  function automatic logic [31:0] cmd_size(input logic [7:0] c, output logic known);
    known = 1'b1;
    if (c >= OP_WAIT_N_LO && c <= OP_WAIT_M_HI) return 32'd1;
    case (c)
      CODE_END, CODE_WAIT_60HZ, CODE_WAIT_50HZ: return 32'd1;
      CODE_WAIT_WORD: return 32'd3;
      CODE_PSG_WRITE: return 32'd2;
      CODE_DATA_BLOCK: return DATA_BLOCK_HDR_LEN;
      CODE_PCM_WRITE: return 32'd12;
      OP_STRM_SETUP, OP_STRM_DATA, OP_STRM_FAST: return 32'd5;
      OP_STRM_FREQ: return 32'd6;
      OP_STRM_START: return 32'd11;
      OP_STRM_STOP: return 32'd2;
      OP_PAIR_WR: return 32'd3;
      default: ;
    endcase
    // remaining codes by high nibble
    case (c[7:4])
      4'h3, 4'h4: return 32'd2;
      4'h5, 4'hA, 4'hB: return 32'd3;
      4'hC, 4'hD: return 32'd4;
      4'hE, 4'hF: return 32'd5;
      default: ;
    endcase
    known = 1'b0;
    return 32'd1;
  endfunction

  function automatic bit is_filtered(input logic [7:0] c, input logic [7:0] r,
                                     input logic [7:0] v, input logic [7:0] p3);
    if (c >= OP_GROUP_LO && c <= OP_WAIT_M_HI) return 1'b1;
    if ((c == OP_FM_A0 || c == OP_FM_A1 || c == OP_FM_C || c == OP_FM_D0 || c == OP_FM_E0) &&
        (r == 8'h2A || (r >= 8'h24 && r <= 8'h27) || (r & 8'hBC) == 8'hB4 ||
         r == 8'h0E || r == 8'h0F))
      return 1'b1;
    if (c == OP_FM_E0 && (r == 8'h1C || (r >= 8'h19 && r <= 8'h1B) || r <= 8'h05 ||
                          (r >= 8'h08 && r <= 8'h0A)))
      return 1'b1;
    if (c == OP_FM_B && r >= 8'h10 && r <= 8'h14) return 1'b1;
    if (((c >= OP_OPL_LO && c <= OP_OPL_HI) || c == OP_OPL_X) && r >= 8'h02 && r <= 8'h04)
      return 1'b1;
    if (c == OP_PCM_Z && (r & 8'hE3) == 8'h03) return 1'b1;
    if (c == OP_RAM_W0 || c == OP_RAM_W1) return 1'b1;
    if (c == OP_REG_A0 && (r == 8'h0E || r == 8'h0F)) return 1'b1;
    if ((c == OP_REG_B0 || c == OP_REG_B1) && r == 8'h07) return 1'b1;
    if (c == OP_REG_B2 && (r & 8'hF0) >= 8'h20 && (r & 8'hF0) <= 8'h40) return 1'b1;
    if (c == OP_REG_D1 && r == 8'h06) return 1'b1;
    if (c == OP_REG_D4 && (r & 8'h7F) == 8'h01 && (v & 8'hF0) == 8'hF0) return 1'b1;
    if (c == OP_REG_B7 && r == 8'h01) return 1'b1;
    if (c == OP_REG_B5 && r >= 8'h01) return 1'b1;
    if (c == OP_MEM_C4 && p3 >= 8'h80) return 1'b1;
    return 1'b0;
  endfunction

  // advance the local parser by one byte; made is set when a word is due
  task automatic parse_byte(input logic [7:0] b, output bit made, output cmd_word_t w);
    logic        known;
    logic [31:0] sz;
    made = 1'b0;
    w = '0;
    if (halted) return;
    if (cur_idx == 0) begin
      cur_code = b;
      cur_len = cmd_size(b, known);
      tail_bytes = '0;
      head_bytes = '0;
      if (b == CODE_WAIT_60HZ) sample_acc = sample_acc + 32'(WAIT_60HZ_SAMPLES);
      else if (b == CODE_WAIT_50HZ) sample_acc = sample_acc + 32'(WAIT_50HZ_SAMPLES);
      else if (b >= OP_WAIT_N_LO && b <= OP_WAIT_N_HI)
        sample_acc = sample_acc + 32'(b[3:0]) + 32'd1;
      else if (b >= OP_WAIT_M_LO && b <= OP_WAIT_M_HI)
        sample_acc = sample_acc + 32'(b[3:0]);
    end else begin
      tail_bytes = {tail_bytes[23:0], b};
      if (cur_idx <= 3) head_bytes = head_bytes | (24'(b) << (8 * (3 - cur_idx)));
      if (cur_code == CODE_DATA_BLOCK && cur_idx == DATA_BLOCK_SIZE_IDX) begin
        // size bytes arrive little-endian
        sz = {tail_bytes[7:0], tail_bytes[15:8], tail_bytes[23:16], tail_bytes[31:24]};
        cur_len = DATA_BLOCK_HDR_LEN + {1'b0, sz[30:0]};
      end
    end
    cur_idx = cur_idx + 32'd1;
    if (cur_idx >= cur_len) begin
      if (cur_code == CODE_WAIT_WORD)
        sample_acc = sample_acc + {16'h0, tail_bytes[7:0], tail_bytes[15:8]};
      if (cur_code == CODE_END ||
          !is_filtered(cur_code, head_bytes[23:16], head_bytes[15:8], head_bytes[7:0])) begin
        void'(cmd_size(cur_code, known));
        w = '{cmd_pos, sample_acc, cur_len[3:0], cur_code, tail_bytes,
              cur_code == CODE_END, !known};
        made = 1'b1;
      end
      cmd_pos = cmd_pos + cur_len;
      cur_idx = '0;
      if (cur_code == CODE_END) halted = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit typed, input cmd_word_t tw);
    int        gap;
    bit        made;
    cmd_word_t w;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    parse_byte(b, made, w);
    if (typed) pending_words.push_back(tw);
    else if (made) pending_words.push_back(w);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_offset(input logic [31:0] v);
    cfg_valid <= 1'b1;
    start_offset <= v;
    do @(posedge clk); while (!cfg_ready);
    cmd_pos = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering bytes until every expected word is back
  task automatic drain();
    int k;
    in_valid <= 1'b0;
    k = 0;
    while (pending_words.size() != 0 && k < DRAIN_LIMIT) begin
      @(negedge clk);
      k++;
    end
    if (pending_words.size() != 0) begin
      report_mismatch("words never produced", 32'd0, pending_words.size());
      pending_words.delete();
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic gen_command();
    logic [7:0]  c;
    logic [7:0]  prm;
    logic [31:0] n;
    logic        known;
    int          sel;
    int          k;
    int          sz;
    if (rx_hold) tx_burst = 1'b1;
    else if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: c = CODE_PSG_WRITE | 8'($urandom_range(0, 15));
      3, 4:    c = OP_REG_A0 + 8'($urandom_range(0, 8'h37));
      5:       c = 8'($urandom_range(CODE_WAIT_WORD, OP_WAIT_M_HI));
      6:       c = CODE_DATA_BLOCK;
      default: c = 8'($urandom);
    endcase
    // end of data would stop the parser for the rest of the run
    if (c == CODE_END) c = CODE_WAIT_50HZ;
    send_byte(c, 1'b0, '0);
    if (c == CODE_DATA_BLOCK) begin
      sz = $urandom_range(0, 12);
      send_byte(CODE_END, 1'b0, '0);
      send_byte(8'($urandom), 1'b0, '0);
      send_byte(8'(sz), 1'b0, '0);
      send_byte(8'h00, 1'b0, '0);
      send_byte(8'h00, 1'b0, '0);
      // top size bit is masked off by the parser
      send_byte({1'($urandom_range(0, 1)), 7'h00}, 1'b0, '0);
      repeat (sz) send_byte(8'($urandom), 1'b0, '0);
    end else begin
      n = cmd_size(c, known);
      for (k = 1; k < n; k++) begin
        prm = 8'($urandom);
        // steer register bytes toward the filter's ranges
        if (k == 1 && $urandom_range(0, 1) == 0)
          prm = 8'($urandom_range(0, 8'h2F));
        else if (k == 1 && $urandom_range(0, 3) == 0)
          prm = 8'hB4 | 8'($urandom_range(0, 3)) | (8'($urandom_range(0, 1)) << 6);
        else if (k == 2 && $urandom_range(0, 3) == 0)
          prm = 8'hF0 | 8'($urandom_range(0, 15));
        send_byte(prm, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin : check_out
    cmd_word_t w;
    if (!rst && in_valid && in_stall) stall_cycles++;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing expected", cmd_position, 32'd0);
      end else begin
        w = pending_words.pop_front();
        if (cmd_position !== w.pos) report_mismatch("cmd_position", cmd_position, w.pos);
        if (sample_count !== w.samples) report_mismatch("sample_count", sample_count, w.samples);
        if (cmd_length !== w.len) report_mismatch("cmd_length", cmd_length, w.len);
        if (cmd_code !== w.code) report_mismatch("cmd_code", cmd_code, w.code);
        if (param_value !== w.params) report_mismatch("param_value", param_value, w.params);
        if (is_end !== w.at_end) report_mismatch("is_end", is_end, w.at_end);
        if (is_unknown !== w.unknown) report_mismatch("is_unknown", is_unknown, w.unknown);
      end
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
    end else if (!rx_hold && rx_wait > 0) begin
      rx_wait = rx_wait - 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= rx_hold || rx_wait > 0;
  end

  // one long output hold-off while the sender keeps going
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : main
    int          ph;
    int unsigned base;
    logic [31:0] ofs;

    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    cfg_valid = 1'b0;
    start_offset = '0;
    out_stall = 1'b0;

    cur_code = '0;
    cur_idx = '0;
    cur_len = '0;
    head_bytes = '0;
    tail_bytes = '0;
    sample_acc = '0;
    cmd_pos = START_OFFSET_RESET;
    halted = 1'b0;

    // directed stream from the reset offset; typed rows are read straight off the spec
    dir_tab[0]  = '{CODE_PSG_WRITE, 1'b0, '0};
    dir_tab[1]  = '{8'hFF, 1'b1, '{32'd64, 32'd0, 4'd2, CODE_PSG_WRITE, 32'h0000_00FF,
                                   1'b0, 1'b0}};
    dir_tab[2]  = '{CODE_WAIT_60HZ, 1'b0, '0};
    dir_tab[3]  = '{OP_WAIT_N_HI, 1'b0, '0};
    dir_tab[4]  = '{OP_WAIT_M_LO, 1'b0, '0};
    dir_tab[5]  = '{OP_WAIT_M_HI, 1'b0, '0};
    dir_tab[6]  = '{CODE_WAIT_WORD, 1'b0, '0};
    dir_tab[7]  = '{8'h34, 1'b0, '0};
    dir_tab[8]  = '{8'h12, 1'b0, '0};
    dir_tab[9]  = '{OP_NONE, 1'b1, '{32'd73, 32'd5426, 4'd1, OP_NONE, 32'd0, 1'b0, 1'b1}};
    dir_tab[10] = '{OP_TOP, 1'b0, '0};
    dir_tab[11] = '{8'hFF, 1'b0, '0};
    dir_tab[12] = '{8'hFF, 1'b0, '0};
    dir_tab[13] = '{8'hFF, 1'b0, '0};
    dir_tab[14] = '{8'hFF, 1'b1, '{32'd74, 32'd5426, 4'd5, OP_TOP, 32'hFFFF_FFFF,
                                   1'b0, 1'b0}};
    dir_tab[15] = '{OP_STRM_FREQ, 1'b0, '0};
    dir_tab[16] = '{8'h01, 1'b0, '0};
    dir_tab[17] = '{8'h02, 1'b0, '0};
    dir_tab[18] = '{8'h03, 1'b0, '0};
    dir_tab[19] = '{8'h04, 1'b0, '0};
    dir_tab[20] = '{8'h05, 1'b0, '0};
    dir_tab[21] = '{OP_REG_B5, 1'b0, '0};
    dir_tab[22] = '{8'h01, 1'b0, '0};
    dir_tab[23] = '{8'h80, 1'b0, '0};

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].w);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       ofs = 32'hFFFF_FFF8;
        1:       ofs = 32'h0000_0000;
        3:       ofs = 32'hFFFF_FFFF;
        4:       ofs = START_OFFSET_RESET;
        default: ofs = $urandom;
      endcase
      write_offset(ofs);
      base = bytes_sent;
      while (bytes_sent - base < PHASE_BYTES) begin
        if (ph == 2 && !hold_go && bytes_sent - base > 40) hold_go = 1'b1;
        gen_command();
      end
    end

    // end of data, then bytes that must be swallowed silently
    drain();
    send_byte(CODE_END, 1'b0, '0);
    send_byte(CODE_END, 1'b0, '0);
    send_byte(8'($urandom), 1'b0, '0);
    send_byte(CODE_PSG_WRITE, 1'b0, '0);
    send_byte(8'($urandom), 1'b0, '0);
    drain();

    $display("Sent %0d stream bytes under %0d start offsets, compared %0d result words",
             bytes_sent, PHASES + 1, words_seen);
    $display("Input was held off for %0d cycles, one long output stall included",
             stall_cycles);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vgmcsp_pkg.sv
rtl/vgmcsp_cmd_decode.sv
rtl/vgmcsp_filter.sv
rtl/vgmcsp_core.sv
bench/tb.sv
